// ----- hw/rtl/eeps_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder edge period speed package
// Shared widths, event kinds and sequencer state codes.
// ----------------------------------------------------------------------------
package eeps_pkg;

    localparam int unsigned NUM_W   = 24;
    localparam int unsigned SPEED_W = 25;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned DIR_W   = 2;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned KIND_W  = 2;

    localparam logic [NUM_W-1:0] NUM_RESET = 24'd162162;

    localparam logic [KIND_W-1:0] KIND_EDGE_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_BWD  = 2'b11;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LIV  = 5'b00010,
        S_NIV  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

// ----- hw/rtl/eeps_div.sv -----
// ----------------------------------------------------------------------------
// Encoder speed serial divider
// Restoring divider, one quotient bit per cycle, numerator over interval.
// ----------------------------------------------------------------------------
module eeps_div import eeps_pkg::*; #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_dividend,
    input  logic [TIME_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quotient
);

    localparam int unsigned RW    = TIME_WIDTH + 1;
    localparam int unsigned CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [RW-1:0]         r_rem, n_rem;
    logic [NUM_W-1:0]      r_quo, n_quo;
    logic [TIME_WIDTH-1:0] r_div, n_div;
    logic [RW-1:0]         w_trial;
    logic [RW-1:0]         w_diff;
    logic                  w_fit;

    assign w_trial = {r_rem[RW-2:0], r_quo[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fit ? w_diff : w_trial;
            n_quo = {r_quo[NUM_W-2:0], w_fit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hw/rtl/encoder_edge_period_speed_core.sv -----
// ----------------------------------------------------------------------------
// Encoder edge period speed core
// Quadrature edge counter with period based speed estimate.
//
// Input stream: one word per encoder event. tuser carries the event kind
// (edge on A, edge on B, speed sample, clear count); tdata carries the level
// of the opposite channel and the microsecond timestamp.
// Output stream: one word per event with signed speed, signed count and
// direction, reflecting the state after the event.
// Config channel: writes the speed numerator; write only while idle.
//
// Input is taken only in the idle state, so one word is in progress at a time.
// The serial divider makes one quotient bit per cycle; interval difference,
// compare and sign are done around it, through S_LIV, S_NIV, S_DIV and S_DONE.
// Until a second qualifying encoder edge is seen, no division runs; S_DONE follows S_IDLE directly.
// A finished word waits in the output register; the next event is taken
// meanwhile, but its result is held until the receiver takes the waiting one.
// Reset clears count, direction, edge times and edge history, and restores
// the numerator to its default.
// ----------------------------------------------------------------------------
module encoder_edge_period_speed_core import eeps_pkg::*; #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,   // other_level, now_us[31:0], zero pad
    input  logic [KIND_W-1:0] i_s_tuser,   // kind
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [63:0]       o_m_tdata,   // speed_rpm[24:0], pulse_count[31:0],
                                           // direction[1:0], zero pad
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [NUM_W-1:0]  i_cfg_data
);

    t_state                r_state, n_state;
    logic [NUM_W-1:0]      r_num;
    logic [TIME_WIDTH-1:0] r_prev, n_prev;
    logic [TIME_WIDTH-1:0] r_last, n_last;
    logic [TIME_WIDTH-1:0] r_now, n_now;
    logic [1:0]            r_edges, n_edges;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [DIR_W-1:0]      r_dir, n_dir;
    logic [TIME_WIDTH-1:0] r_liv, n_liv;
    logic [SPEED_W-1:0]    r_speed, n_speed;
    logic                  r_ovalid, n_ovalid;
    logic [63:0]           r_odata, n_odata;

    logic                  w_accept;
    logic                  w_cfg;
    logic                  w_edge;
    logic [TIME_WIDTH-1:0] w_stamp;
    logic [TIME_WIDTH-1:0] w_niv;
    logic [TIME_WIDTH-1:0] w_iv;
    logic                  w_start;
    logic                  w_done;
    logic [NUM_W-1:0]      w_quo;
    logic [SPEED_W-1:0]    w_q_ext;

    generate
        if (TIME_WIDTH > STAMP_W) begin : g_wide
            assign w_stamp = {{(TIME_WIDTH-STAMP_W){1'b0}}, i_s_tdata[32:1]};
        end else if (TIME_WIDTH == STAMP_W) begin : g_same
            assign w_stamp = i_s_tdata[32:1];
        end else begin : g_narrow
            assign w_stamp = i_s_tdata[TIME_WIDTH:1];
        end
    endgenerate

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_cfg       = i_cfg_valid && o_cfg_ready;
    assign w_edge      = !i_s_tdata[0]
                         && ((i_s_tuser == KIND_EDGE_A) || (i_s_tuser == KIND_EDGE_B));

    assign w_niv   = r_now - r_last;
    assign w_q_ext = {1'b0, w_quo};

    always_comb begin
        w_iv = (r_liv < w_niv) ? w_niv : r_liv;
        if (w_iv == '0) begin
            w_iv = TIME_WIDTH'(1);
        end
    end

    assign w_start = (r_state == S_NIV);

    eeps_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_num),
        .i_divisor  (w_iv),
        .o_done     (w_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state  = r_state;
        n_prev   = r_prev;
        n_last   = r_last;
        n_now    = r_now;
        n_edges  = r_edges;
        n_count  = r_count;
        n_dir    = r_dir;
        n_liv    = r_liv;
        n_speed  = r_speed;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_now   = w_stamp;
                    n_speed = '0;
                    if (w_edge) begin
                        n_prev = r_last;
                        n_last = w_stamp;
                        if (r_edges != 2'd2) begin
                            n_edges = r_edges + 1'b1;
                        end
                        if (i_s_tuser == KIND_EDGE_A) begin
                            n_count = r_count + 1'b1;
                            n_dir   = DIR_FWD;
                        end else begin
                            n_count = r_count - 1'b1;
                            n_dir   = DIR_BWD;
                        end
                    end else if (i_s_tuser == KIND_CLEAR) begin
                        n_count = '0;
                    end
                    if (n_edges == 2'd2 && n_dir != DIR_NONE) begin
                        n_state = S_LIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LIV: begin
                n_liv   = r_last - r_prev;
                n_state = S_NIV;
            end
            S_NIV: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_done) begin
                    n_speed = (r_dir == DIR_BWD) ? (SPEED_W'(0) - w_q_ext) : w_q_ext;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {5'd0, r_dir, r_count, r_speed};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_num    <= NUM_RESET;
            r_prev   <= '0;
            r_last   <= '0;
            r_edges  <= '0;
            r_count  <= '0;
            r_dir    <= DIR_NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prev   <= n_prev;
            r_last   <= n_last;
            r_edges  <= n_edges;
            r_count  <= n_count;
            r_dir    <= n_dir;
            r_ovalid <= n_ovalid;
            if (w_cfg) begin
                r_num <= i_cfg_data;
            end
        end
        r_now   <= n_now;
        r_liv   <= n_liv;
        r_speed <= n_speed;
        r_odata <= n_odata;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("input taken while an event is in progress");

    a_edges_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges != 2'd3)
        else $error("edge history beyond two");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_div_needs_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dir != DIR_NONE && r_edges == 2'd2))
        else $error("divide started without two edges and a direction");

endmodule
